@@ rtl/ise_pkg.sv @@
`timescale 1ns / 1ps

package ise_pkg;

	// default depth of the sorting chain
	localparam int unsigned MAX_ITEMS_DEF = 64;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} out_word_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic               valid;
		logic               gt;
		logic signed [31:0] value;
	} cell_link_t;

endpackage

@@ rtl/ise_cell.sv @@
`timescale 1ns / 1ps

module ise_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ins,
	input  logic                      pop,
	input  logic signed [31:0]        value,
	input  ise_pkg::cell_link_t       lower,
	input  ise_pkg::cell_link_t       upper,
	output ise_pkg::cell_link_t       link
);
	import ise_pkg::*;

	logic               valid_q;
	logic signed [31:0] value_q;
	logic               gt;
	logic               take_new;

	// strictly greater entries move up, so equal values keep arrival order
	assign gt       = valid_q && (value_q > value);
	assign take_new = !lower.gt && (gt || (!valid_q && lower.valid));

	assign link.valid = valid_q;
	assign link.gt    = gt;
	assign link.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= upper.valid;
		end else if (ins && (lower.gt || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= upper.value;
		end else if (ins && lower.gt) begin
			value_q <= lower.value;
		end else if (ins && take_new) begin
			value_q <= value;
		end
	end

endmodule

@@ rtl/insertion_sort_engine_core.sv @@
`timescale 1ns / 1ps

// Streaming stable insertion sorter built as a chain of MAX_ITEMS compare-and-shift
// cells. Each accepted word carries one signed 32-bit value; it is broadcast to every
// cell, and in the same cycle every cell holding a strictly greater value passes it one
// place up while the cell at the gap takes the new value, so one word is taken per
// cycle while a set is being collected and equal values come out in arrival order.
// A word with last set closes the set (it is inserted first unless the chain is full).
// The chain then shifts down one cell per cycle into the output register, giving one
// sorted word per cycle that the downstream side does not stall; in_stall is high for
// the whole drain. Values arriving while all MAX_ITEMS cells are occupied are dropped,
// and every word of that set's sorted run then carries overflow. last_out marks the
// final word of each run.
module insertion_sort_engine_core #(
	parameter int unsigned MAX_ITEMS = ise_pkg::MAX_ITEMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ise_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ise_pkg::out_word_t   out_word
);
	import ise_pkg::*;

	// per-cell links, with one tied-off neighbor at each end of the chain
	cell_link_t           link  [MAX_ITEMS];
	cell_link_t           lower [MAX_ITEMS];
	cell_link_t           upper [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] occupied;

	logic      draining_q;
	logic      dropped_q;
	logic      out_valid_q;
	out_word_t out_q;

	logic in_take;
	logic full;
	logic ins;
	logic pop;
	logic pop_final;

	assign full      = link[MAX_ITEMS-1].valid;
	assign in_stall  = draining_q;
	assign in_take   = in_valid && !draining_q;
	assign ins       = in_take && !full;
	// move one word out whenever the output register is free or being taken
	assign pop       = draining_q && (!out_valid_q || !out_stall);
	assign pop_final = pop && !link[1].valid;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			if (gi == 0) begin : g_bottom
				// below the bottom cell sits an occupied, never-greater entry
				assign lower[gi] = '{valid: 1'b1, gt: 1'b0, value: '0};
			end else begin : g_mid_lo
				assign lower[gi] = link[gi-1];
			end
			if (gi == MAX_ITEMS - 1) begin : g_top
				// empty slot shifted in at the top while draining
				assign upper[gi] = '{valid: 1'b0, gt: 1'b0, value: '0};
			end else begin : g_mid_hi
				assign upper[gi] = link[gi+1];
			end

			ise_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ins    (ins),
				.pop    (pop),
				.value  (in_word.value),
				.lower  (lower[gi]),
				.upper  (upper[gi]),
				.link   (link[gi])
			);

			assign occupied[gi] = link[gi].valid;
		end
	endgenerate

	// set control: drain after a last word, overflow marker for the set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (pop_final) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (in_take) begin
			if (full) begin
				dropped_q <= 1'b1;
			end
			if (in_word.last) begin
				draining_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.sorted_value <= link[0].value;
			out_q.last_out     <= !link[1].valid;
			out_q.overflow     <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// occupied cells always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, occupied} + {{MAX_ITEMS{1'b0}}, 1'b1}))
		else $error("occupied cells are not contiguous from the bottom");

	// a closing word always starts a drain
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_word.last) |=> draining_q)
		else $error("last word did not start the drain");

	// the final pop ends the drain and leaves the chain empty
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop_final |=> (!draining_q && !dropped_q && !link[0].valid))
		else $error("drain did not finish cleanly");

	// a drain never runs dry before its final word
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> link[0].valid)
		else $error("popped an empty cell");

endmodule
